// ----- src/utf8d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the utf-8 stream decoder
// Field widths, byte tags, sequence length codes and the work descriptor
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;

   // replacement character for malformed input
   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // top two bits of a continuation byte
   localparam logic [1:0] CONT_TAG = 2'b10;

   // lead byte tags
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;

   // expected sequence length codes
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // results of one byte: pre_cnt replacements, an optional code point,
   // then post_cnt replacements for an end-of-text flush
   typedef struct packed {
      logic [1:0]      pre_cnt;
      logic            has_mid;
      logic [CP_W-1:0] mid_cp;
      logic [1:0]      post_cnt;
      logic            fin;
   } desc_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     not_empty;
      desc_type desc;
   } queue_head_type;

endpackage : utf8d_pkg
`default_nettype wire

// ----- src/utf8d_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_ifs: channel interfaces of the utf-8 stream decoder
// Byte request channel and code point response channel, valid/ready.
// ----------------------------------------------------------------------------
interface utf8d_req_if;
   import utf8d_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface : utf8d_req_if

interface utf8d_rsp_if;
   import utf8d_pkg::*;

   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            run_end;
   logic            text_end;

   modport source (output valid, output code_point, output run_end, output text_end,
                   input ready);
   modport sink   (input valid, input code_point, input run_end, input text_end,
                   output ready);
endinterface : utf8d_rsp_if
`default_nettype wire

// ----- src/utf8_stream_decoder.sv -----
// path: a byte's descriptor is registered in the queue, and each of its results then in the response register
// throughput: one byte per cycle in while the queue has room, one result per cycle out
// while the sink is ready; a byte with more than one result holds the result register for each
// of them in turn, the descriptor queue absorbs the difference until it fills
// reset: synchronous, clears the pending sequence, the queue and the output
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming utf-8 to code point decoder
// Front end classifies bytes, a descriptor queue decouples it from the
// back end, which emits one code point per transaction.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   utf8d_req_if.sink   req,
   utf8d_rsp_if.source rsp
);
   import utf8d_pkg::*;

   logic           push_valid;
   desc_type       push_desc;
   logic           push_ready;
   queue_head_type head;
   logic           pop;

   // byte intake
   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready)
   );

   // descriptor queue
   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // result expansion
   utf8d_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule : utf8_stream_decoder
`default_nettype wire

// ----- src/utf8d_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front: byte intake and classification
// Holds the pending sequence, classifies each byte and pushes a descriptor
// of the results it causes into the queue.
// ----------------------------------------------------------------------------
module utf8d_front (
   input  wire logic               clock,
   input  wire logic               reset,
   utf8d_req_if.sink               req,
   output      logic               push_valid,
   output      utf8d_pkg::desc_type push_desc,
   input  wire logic               push_ready
);
   import utf8d_pkg::*;

   logic [2:0]      exp_len_ff, exp_len_in;
   logic [1:0]      held_ff, held_in;
   logic [CP_W-1:0] accum_ff, accum_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic              consumed;
   logic [2:0]        held_inc;
   logic [CP_W-1:0]   accum_cat;
   logic [2:0]        total;
   desc_type          desc;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign b         = req.text_byte;

   // classify the byte against the pending sequence
   always_comb begin
      desc       = '0;
      exp_len_in = exp_len_ff;
      held_in    = held_ff;
      accum_in   = accum_ff;
      consumed   = (exp_len_ff != LEN_NONE) && (b[7:6] == CONT_TAG);
      held_inc   = {1'b0, held_ff} + 3'd1;
      accum_cat  = {accum_ff[CP_W-7:0], b[5:0]};

      if (consumed) begin
         if (held_inc >= exp_len_ff) begin
            desc.has_mid = 1'b1;
            desc.mid_cp  = accum_cat;
            exp_len_in   = LEN_NONE;
            held_in      = '0;
            accum_in     = '0;
         end else begin
            held_in  = held_inc[1:0];
            accum_in = accum_cat;
         end
      end else begin
         // interrupted sequence: one replacement per held byte
         if (exp_len_ff != LEN_NONE) begin
            desc.pre_cnt = held_ff;
         end
         exp_len_in = LEN_NONE;
         held_in    = '0;
         accum_in   = '0;
         if (!b[7]) begin
            desc.has_mid = 1'b1;
            desc.mid_cp  = CP_W'(b);
         end else if (b[7:5] == LEAD2_TAG) begin
            exp_len_in = LEN_TWO;
            held_in    = 2'd1;
            accum_in   = CP_W'(b[4:0]);
         end else if (b[7:4] == LEAD3_TAG) begin
            exp_len_in = LEN_THREE;
            held_in    = 2'd1;
            accum_in   = CP_W'(b[3:0]);
         end else if (b[7:3] == LEAD4_TAG) begin
            exp_len_in = LEN_FOUR;
            held_in    = 2'd1;
            accum_in   = CP_W'(b[2:0]);
         end else begin
            desc.has_mid = 1'b1;
            desc.mid_cp  = REPLACEMENT_CP;
         end
      end

      // end of text flushes whatever is still pending
      if (req.final_byte && (exp_len_in != LEN_NONE)) begin
         desc.post_cnt = held_in;
         exp_len_in    = LEN_NONE;
         held_in       = '0;
         accum_in      = '0;
      end
      desc.fin = req.final_byte;
   end

   assign total      = {1'b0, desc.pre_cnt} + {2'b00, desc.has_mid} + {1'b0, desc.post_cnt};
   assign push_valid = accept && (total != 3'd0);
   assign push_desc  = desc;

   // pending sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= LEN_NONE;
         held_ff    <= '0;
         accum_ff   <= '0;
      end else if (accept) begin
         exp_len_ff <= exp_len_in;
         held_ff    <= held_in;
         accum_ff   <= accum_in;
      end
   end

endmodule : utf8d_front
`default_nettype wire

// ----- src/utf8d_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue: descriptor queue between front and back end
// Small circular buffer so that intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module utf8d_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire utf8d_pkg::desc_type      push_desc,
   output      logic                     push_ready,
   output      utf8d_pkg::queue_head_type head,
   input  wire logic                     pop
);
   import utf8d_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready     = (count_ff != CNT_W'(DEPTH));
   assign do_push        = push_valid && push_ready;
   assign do_pop         = pop && (count_ff != '0);
   assign head.not_empty = (count_ff != '0);
   assign head.desc      = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // descriptor storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule : utf8d_queue
`default_nettype wire

// ----- src/utf8d_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back: result expansion
// Walks each descriptor one result per cycle, while the sink is ready, into the response register.
// ----------------------------------------------------------------------------
module utf8d_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire utf8d_pkg::queue_head_type head,
   output      logic                     pop,
   utf8d_rsp_if.source                   rsp
);
   import utf8d_pkg::*;

   logic [1:0]      idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   logic [CP_W-1:0] out_cp_ff;
   logic            out_run_ff;
   logic            out_text_ff;

   logic            load;
   logic [2:0]      total;
   logic            last;
   logic [CP_W-1:0] cp;

   // position within the current descriptor
   assign total = {1'b0, head.desc.pre_cnt} + {2'b00, head.desc.has_mid}
                + {1'b0, head.desc.post_cnt};
   assign last  = ({1'b0, idx_ff} == (total - 3'd1));
   assign cp    = (head.desc.has_mid && (idx_ff == head.desc.pre_cnt)) ? head.desc.mid_cp
                                                                        : REPLACEMENT_CP;
   assign load  = head.not_empty && (!out_valid_ff || rsp.ready);
   assign pop   = load && last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = last ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (load) begin
         out_cp_ff   <= cp;
         out_run_ff  <= last;
         out_text_ff <= last && head.desc.fin;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.code_point = out_cp_ff;
   assign rsp.run_end    = out_run_ff;
   assign rsp.text_end   = out_text_ff;

endmodule : utf8d_back
`default_nettype wire
